>>> design/dta_pkg.sv
// shared types and constants for the descriptor table allocator
// no dependencies; imported by dta_ctrl, dta_datapath, the top level and the testbench
package dta_pkg;

    localparam int SLOTS        = 64;
    localparam int HANDLE_WIDTH = 32;
    localparam int SLOT_W       = 8;
    localparam int SLOT_IDX_W   = $clog2(SLOTS);
    localparam int LEN_W        = $clog2(SLOTS + 1);
    localparam int TGT_W        = SLOT_W + 1;
    localparam int STATUS_W     = 2;
    localparam int OPCODE_W     = 4;

    localparam int IN_FIELDS_W  = OPCODE_W + 2 * SLOT_W + HANDLE_WIDTH + 1;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = STATUS_W + SLOT_W + HANDLE_WIDTH + 1;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT_LOWEST = 4'd0,
        OP_INSERT_AT     = 4'd1,
        OP_LOOKUP        = 4'd2,
        OP_REMOVE        = 4'd3,
        OP_REMOVE_RANGE  = 4'd4,
        OP_FLAG_RANGE    = 4'd5,
        OP_SET_FLAG      = 4'd6,
        OP_TEST_FLAG     = 4'd7,
        OP_EXEC_CLEAR    = 4'd8
    } t_opcode;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_cmd;

endpackage

>>> design/dta_ram.sv
// generic single write port ram with registered read
// no dependencies
module dta_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/dta_ctrl.sv
// controller state machine: capture, execute, hold result
// depends on dta_pkg
module dta_ctrl
    import dta_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_RESP = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   in_ready;
    logic   accept;

    assign in_ready = (r_state == S_IDLE) || ((r_state == S_RESP) && i_out_ready);
    assign accept   = in_ready && i_in_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                if (accept) n_state = S_EXEC;
                else if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = (r_state == S_RESP);
    assign o_cmd.load  = accept;
    assign o_cmd.exec  = (r_state == S_EXEC);

endmodule

>>> design/dta_datapath.sv
// datapath: valid and close-on-exec bitmaps, length, handle ram, result registers
// depends on dta_pkg and dta_ram
module dta_datapath
    import dta_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    input  logic [OPCODE_W-1:0]     i_opcode,
    input  logic [SLOT_W-1:0]       i_slot,
    input  logic [SLOT_W-1:0]       i_slot_high,
    input  logic [HANDLE_WIDTH-1:0] i_handle,
    input  logic                    i_close_flag,
    output logic [STATUS_W-1:0]     o_status,
    output logic [SLOT_W-1:0]       o_slot_out,
    output logic [HANDLE_WIDTH-1:0] o_handle_out,
    output logic                    o_flag_out
);

    logic [OPCODE_W-1:0]     r_op;
    logic [SLOT_W-1:0]       r_slot;
    logic [SLOT_W-1:0]       r_slot_high;
    logic [HANDLE_WIDTH-1:0] r_handle;
    logic                    r_close;

    logic [SLOTS-1:0]        r_valid, n_valid;
    logic [SLOTS-1:0]        r_exec, n_exec;
    logic [LEN_W-1:0]        r_len, n_len;

    logic [STATUS_W-1:0]     r_status, n_status;
    logic [SLOT_W-1:0]       r_slot_out, n_slot_out;
    logic [HANDLE_WIDTH-1:0] r_handle_out, n_handle_out;
    logic                    r_flag_out, n_flag_out;

    logic [HANDLE_WIDTH-1:0] rd_data;
    logic                    wr_en;
    logic [SLOT_IDX_W-1:0]   wr_addr;

    logic [TGT_W-1:0]        slot_x, slot_high_x, len_x, len_m1;
    logic [TGT_W-1:0]        lo, hi, floor_tgt, ins_tgt, ins_tgt_p1;
    logic [SLOT_IDX_W-1:0]   sidx, free_idx;
    logic [SLOTS-1:0]        free_vec, free_low, range_mask;
    logic                    free_found, present, ins_full, at_full;

    dta_ram #(
        .WIDTH(HANDLE_WIDTH),
        .DEPTH(SLOTS)
    ) u_handle_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(r_handle),
        .i_rd_addr(i_slot[SLOT_IDX_W-1:0]),
        .o_rd_data(rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op        <= i_opcode;
            r_slot      <= i_slot;
            r_slot_high <= i_slot_high;
            r_handle    <= i_handle;
            r_close     <= i_close_flag;
        end
        if (i_cmd.exec) begin
            r_status     <= n_status;
            r_slot_out   <= n_slot_out;
            r_handle_out <= n_handle_out;
            r_flag_out   <= n_flag_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_exec  <= '0;
            r_len   <= '0;
        end else if (i_cmd.exec) begin
            r_valid <= n_valid;
            r_exec  <= n_exec;
            r_len   <= n_len;
        end
    end

    // shared decode of the captured operation
    always_comb begin
        slot_x      = TGT_W'(r_slot);
        slot_high_x = TGT_W'(r_slot_high);
        len_x       = TGT_W'(r_len);
        len_m1      = len_x - TGT_W'(1);
        sidx        = r_slot[SLOT_IDX_W-1:0];
        present     = (slot_x < len_x) && (slot_x < TGT_W'(SLOTS)) && r_valid[sidx];

        // lowest free slot at or above the floor and below length
        for (int i = 0; i < SLOTS; i++) begin
            free_vec[i] = !r_valid[i] && (TGT_W'(i) >= slot_x) && (TGT_W'(i) < len_x);
        end
        free_low   = free_vec & (~free_vec + SLOTS'(1));
        free_found = |free_vec;
        free_idx   = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (free_low[i]) free_idx = free_idx | SLOT_IDX_W'(i);
        end
        floor_tgt = (slot_x > len_x) ? slot_x : len_x;
        ins_tgt   = free_found ? TGT_W'(free_idx) : floor_tgt;
        ins_full  = ins_tgt >= TGT_W'(SLOTS);
        at_full   = slot_x >= TGT_W'(SLOTS);

        // clamped range
        lo = (slot_x < len_m1) ? slot_x : len_m1;
        hi = (slot_high_x < len_m1) ? slot_high_x : len_m1;
        for (int i = 0; i < SLOTS; i++) begin
            range_mask[i] = (r_len != '0) && (TGT_W'(i) >= lo) && (TGT_W'(i) <= hi)
                            && r_valid[i];
        end
    end

    always_comb begin
        n_valid      = r_valid;
        n_exec       = r_exec;
        n_len        = r_len;
        n_status     = ST_OK;
        n_slot_out   = r_slot;
        n_handle_out = '0;
        n_flag_out   = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = sidx;
        ins_tgt_p1   = '0;

        unique case (r_op) inside
            OP_INSERT_LOWEST, OP_INSERT_AT: begin
                if (r_op == OP_INSERT_AT) begin
                    ins_tgt_p1 = slot_x + TGT_W'(1);
                    wr_addr    = sidx;
                end else begin
                    ins_tgt_p1 = ins_tgt + TGT_W'(1);
                    wr_addr    = ins_tgt[SLOT_IDX_W-1:0];
                end
                if ((r_op == OP_INSERT_AT) ? at_full : ins_full) begin
                    n_status = ST_FULL;
                end else begin
                    wr_en            = i_cmd.exec;
                    n_valid[wr_addr] = 1'b1;
                    n_exec[wr_addr]  = r_close;
                    if (ins_tgt_p1 > len_x) n_len = LEN_W'(ins_tgt_p1);
                    if (r_op == OP_INSERT_LOWEST) n_slot_out = ins_tgt[SLOT_W-1:0];
                end
            end
            OP_LOOKUP: begin
                if (present) n_handle_out = rd_data;
                else n_status = ST_ABSENT;
            end
            OP_REMOVE: begin
                if (present) begin
                    n_valid[sidx] = 1'b0;
                    n_exec[sidx]  = 1'b0;
                end else begin
                    n_status = ST_ABSENT;
                end
            end
            OP_REMOVE_RANGE: begin
                n_valid = r_valid & ~range_mask;
                n_exec  = r_exec & ~range_mask;
            end
            OP_FLAG_RANGE: begin
                n_exec = r_exec | range_mask;
            end
            OP_SET_FLAG: begin
                if (present) n_exec[sidx] = 1'b1;
                else n_status = ST_ABSENT;
            end
            OP_TEST_FLAG: begin
                if (present) n_flag_out = r_exec[sidx];
                else n_status = ST_ABSENT;
            end
            OP_EXEC_CLEAR: begin
                n_valid = r_valid & ~r_exec;
                n_exec  = '0;
            end
            default: begin
            end
        endcase
    end

    assign o_status     = r_status;
    assign o_slot_out   = r_slot_out;
    assign o_handle_out = r_handle_out;
    assign o_flag_out   = r_flag_out;

endmodule

>>> design/descriptor_table_allocator.sv
// Descriptor table allocator: a 64-entry table of 32-bit handles with valid and
// close-on-exec bitmaps and a high-water length. Each transfer in carries one
// operation and gives exactly one result transfer. An operation is captured as it
// is accepted, with the handle ram read (registered read), then executed against
// the bitmaps in the execute state, which loads the result register. A new transfer is taken in
// the same cycle the previous result leaves, so a new operation can overlap the
// last result, but none is taken while one executes. The handle store has no reset; only valid entries are read.
// depends on dta_pkg, dta_ctrl, dta_datapath, dta_ram
module descriptor_table_allocator
    import dta_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // opcode[3:0], slot[11:4], slot_high[19:12], handle[51:20], close_flag[52]
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // status[1:0], slot_out[9:2], handle_out[41:10], flag_out[42]
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    localparam int SLOT_LSB   = OPCODE_W;
    localparam int SHIGH_LSB  = SLOT_LSB + SLOT_W;
    localparam int HANDLE_LSB = SHIGH_LSB + SLOT_W;
    localparam int CLOSE_LSB  = HANDLE_LSB + HANDLE_WIDTH;

    t_dp_cmd                 cmd;
    logic [STATUS_W-1:0]     status;
    logic [SLOT_W-1:0]       slot_out;
    logic [HANDLE_WIDTH-1:0] handle_out;
    logic                    flag_out;

    dta_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .o_out_valid(o_m_axis_tvalid),
        .i_out_ready(i_m_axis_tready),
        .o_cmd      (cmd)
    );

    dta_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_opcode    (i_s_axis_tdata[OPCODE_W-1:0]),
        .i_slot      (i_s_axis_tdata[SLOT_LSB +: SLOT_W]),
        .i_slot_high (i_s_axis_tdata[SHIGH_LSB +: SLOT_W]),
        .i_handle    (i_s_axis_tdata[HANDLE_LSB +: HANDLE_WIDTH]),
        .i_close_flag(i_s_axis_tdata[CLOSE_LSB]),
        .o_status    (status),
        .o_slot_out  (slot_out),
        .o_handle_out(handle_out),
        .o_flag_out  (flag_out)
    );

    assign o_m_axis_tdata = OUT_DATA_W'({flag_out, handle_out, slot_out, status});

    // an accepted transfer blocks input for the execute cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input ready during execute");

    // every accepted transfer yields a result once the execute state is done
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> ##1 o_m_axis_tvalid)
        else $error("result missing after accept");

    // execute only ever follows a capture
    a_exec_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.exec |-> $past(cmd.load))
        else $error("execute without capture");

    // lookup data only on a good status
    a_handle_on_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (handle_out != '0)) |-> (status == ST_OK))
        else $error("handle returned with error status");

endmodule

>>> verif/descriptor_table_allocator_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for descriptor_table_allocator: directed and random table
// operations, with random idling on both stream sides; depends on dta_pkg and the design
module descriptor_table_allocator_tb;
    import dta_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 5;
    localparam int RANDOM_ITEMS   = 900;
    localparam int BLOCK_ITEMS    = 100;
    localparam int HOLD_AT        = 400;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int REPORT_LIMIT   = 10;

    localparam int MIX_FILL  = 0;
    localparam int MIX_CHURN = 1;
    localparam int MIX_DRAIN = 2;

    localparam logic [OPCODE_W-1:0] OP_FIRST_UNUSED = OPCODE_W'(OP_EXEC_CLEAR + 1);
    localparam logic [OPCODE_W-1:0] OP_LAST_UNUSED  = '1;

    typedef struct {
        logic [OPCODE_W-1:0]     opcode;
        logic [SLOT_W-1:0]       slot;
        logic [SLOT_W-1:0]       slot_high;
        logic [HANDLE_WIDTH-1:0] handle;
        logic                    close_flag;
        bit                      wait_idle;
    } t_table_req;

    typedef struct {
        logic [STATUS_W-1:0]     status;
        logic [SLOT_W-1:0]       slot_out;
        logic [HANDLE_WIDTH-1:0] handle_out;
        logic                    flag_out;
    } t_table_resp;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    t_table_req  pending_ops[$];
    t_table_resp expected_results[$];

    // shadow copy of the table
    logic [HANDLE_WIDTH-1:0] tbl_handle [SLOTS];
    bit                      tbl_valid [SLOTS];
    bit                      tbl_cloexec [SLOTS];
    int                      tbl_len = 0;

    t_table_req  cur_op;
    logic        next_valid = 1'b0;
    int          send_gap = 0;
    int          send_calm = 0;
    int          sink_gap = 0;
    int          sink_calm = 0;
    bit          hold_done = 0;
    int          results_seen = 0;
    int          mismatch_count = 0;
    int          idle_cycles = 0;

    descriptor_table_allocator uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic bit slot_live(int s);
        return (s < tbl_len) && tbl_valid[s];
    endfunction

    function automatic void store_entry(int s, logic [HANDLE_WIDTH-1:0] h, logic cl);
        tbl_handle[s]  = h;
        tbl_valid[s]   = 1'b1;
        tbl_cloexec[s] = cl;
        if (s + 1 > tbl_len) tbl_len = s + 1;
    endfunction

    function automatic t_table_resp apply_table_op(t_table_req r);
        t_table_resp res;
        int idx;
        int lo;
        int hi;
        res.status     = ST_OK;
        res.slot_out   = r.slot;
        res.handle_out = '0;
        res.flag_out   = 1'b0;
        case (r.opcode)
            OP_INSERT_LOWEST: begin
                idx = int'(r.slot);
                while (idx < tbl_len && tbl_valid[idx]) idx++;
                if (idx >= SLOTS) begin
                    res.status = ST_FULL;
                end else begin
                    store_entry(idx, r.handle, r.close_flag);
                    res.slot_out = SLOT_W'(idx);
                end
            end
            OP_INSERT_AT: begin
                if (int'(r.slot) >= SLOTS) res.status = ST_FULL;
                else store_entry(int'(r.slot), r.handle, r.close_flag);
            end
            OP_LOOKUP: begin
                if (slot_live(int'(r.slot))) res.handle_out = tbl_handle[r.slot];
                else res.status = ST_ABSENT;
            end
            OP_REMOVE: begin
                if (slot_live(int'(r.slot))) begin
                    tbl_valid[r.slot]   = 1'b0;
                    tbl_cloexec[r.slot] = 1'b0;
                end else begin
                    res.status = ST_ABSENT;
                end
            end
            OP_REMOVE_RANGE, OP_FLAG_RANGE: begin
                if (tbl_len != 0) begin
                    lo = (int'(r.slot) < tbl_len - 1) ? int'(r.slot) : tbl_len - 1;
                    hi = (int'(r.slot_high) < tbl_len - 1) ? int'(r.slot_high) : tbl_len - 1;
                    for (int i = lo; i <= hi; i++) begin
                        if (tbl_valid[i]) begin
                            if (r.opcode == OP_REMOVE_RANGE) begin
                                tbl_valid[i]   = 1'b0;
                                tbl_cloexec[i] = 1'b0;
                            end else begin
                                tbl_cloexec[i] = 1'b1;
                            end
                        end
                    end
                end
            end
            OP_SET_FLAG: begin
                if (slot_live(int'(r.slot))) tbl_cloexec[r.slot] = 1'b1;
                else res.status = ST_ABSENT;
            end
            OP_TEST_FLAG: begin
                if (slot_live(int'(r.slot))) res.flag_out = tbl_cloexec[r.slot];
                else res.status = ST_ABSENT;
            end
            OP_EXEC_CLEAR: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (tbl_cloexec[i]) tbl_valid[i] = 1'b0;
                    tbl_cloexec[i] = 1'b0;
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    task automatic add_op(input logic [OPCODE_W-1:0] op, input int s, input int sh,
                          input logic [HANDLE_WIDTH-1:0] h, input logic cl);
        t_table_req r;
        r.opcode     = op;
        r.slot       = SLOT_W'(s);
        r.slot_high  = SLOT_W'(sh);
        r.handle     = h;
        r.close_flag = cl;
        r.wait_idle  = 1'b0;
        pending_ops.push_back(r);
    endtask

    task automatic add_idle_wait();
        t_table_req r;
        r = '{default: '0};
        r.wait_idle = 1'b1;
        pending_ops.push_back(r);
    endtask

    function automatic int rand_slot();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(0, SLOTS - 1);
        if (r < 85) return $urandom_range(SLOTS - 4, SLOTS + 4);
        return $urandom_range(0, (1 << SLOT_W) - 1);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // returns the number of transfers queued
    task automatic add_random_op(input int mix, output int added);
        int r;
        int s;
        logic [OPCODE_W-1:0] op;
        r = $urandom_range(0, 99);
        added = 1;
        case (mix)
            MIX_FILL: begin
                if (r < 55) op = OP_INSERT_LOWEST;
                else if (r < 65) op = OP_INSERT_AT;
                else if (r < 80) op = OP_LOOKUP;
                else if (r < 88) op = OP_TEST_FLAG;
                else if (r < 94) op = OP_SET_FLAG;
                else if (r < 97) op = OP_FLAG_RANGE;
                else op = OP_REMOVE;
            end
            MIX_CHURN: begin
                if (r < 25) op = OP_INSERT_LOWEST;
                else if (r < 35) op = OP_INSERT_AT;
                else if (r < 50) op = OP_LOOKUP;
                else if (r < 62) op = OP_REMOVE;
                else if (r < 67) op = OP_REMOVE_RANGE;
                else if (r < 72) op = OP_FLAG_RANGE;
                else if (r < 80) op = OP_SET_FLAG;
                else if (r < 90) op = OP_TEST_FLAG;
                else if (r < 93) op = OP_EXEC_CLEAR;
                else if (r < 96)
                    op = OPCODE_W'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
                else op = OP_LOOKUP;
            end
            default: begin
                if (r < 30) op = OP_REMOVE;
                else if (r < 40) op = OP_REMOVE_RANGE;
                else if (r < 45) op = OP_EXEC_CLEAR;
                else if (r < 60) op = OP_LOOKUP;
                else if (r < 70) op = OP_TEST_FLAG;
                else if (r < 80) op = OP_FLAG_RANGE;
                else if (r < 90) op = OP_INSERT_LOWEST;
                else op = OPCODE_W'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
            end
        endcase
        if (op == OP_INSERT_LOWEST && $urandom_range(0, 99) < 60) s = $urandom_range(0, 7);
        else s = rand_slot();
        add_op(op, s, rand_slot(), $urandom, 1'($urandom_range(0, 1)));
        // sometimes follow an insert at a given slot with a read of the same slot
        if (op == OP_INSERT_AT && $urandom_range(0, 99) < 40) begin
            add_op($urandom_range(0, 1) ? OP_LOOKUP : OP_TEST_FLAG, s, rand_slot(),
                   $urandom, 1'($urandom_range(0, 1)));
            added = 2;
        end
    endtask

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) $display("mismatch: %s", msg);
    endtask

    // source side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            next_valid = s_tvalid;
            if (s_tvalid && s_tready) begin
                expected_results.push_back(apply_table_op(cur_op));
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_ops.size() != 0) begin
                    if (pending_ops[0].wait_idle) begin
                        if (expected_results.size() == 0) void'(pending_ops.pop_front());
                    end else begin
                        cur_op = pending_ops.pop_front();
                        s_tdata <= IN_DATA_W'({cur_op.close_flag, cur_op.handle,
                                               cur_op.slot_high, cur_op.slot, cur_op.opcode});
                        next_valid = 1'b1;
                        if (send_calm > 0) begin
                            send_calm--;
                            send_gap = 0;
                        end else begin
                            send_gap = pick_gap();
                            if ($urandom_range(0, 49) == 0) send_calm = $urandom_range(20, 60);
                        end
                    end
                end
            end
            s_tvalid <= next_valid;
        end
    end

    // sink side and result check
    always @(posedge i_clk) begin
        t_table_resp got;
        t_table_resp exp_res;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.status     = m_tdata[STATUS_W-1:0];
                got.slot_out   = m_tdata[STATUS_W +: SLOT_W];
                got.handle_out = m_tdata[STATUS_W + SLOT_W +: HANDLE_WIDTH];
                got.flag_out   = m_tdata[STATUS_W + SLOT_W + HANDLE_WIDTH];
                results_seen++;
                if (expected_results.size() == 0) begin
                    note_mismatch($sformatf("unexpected result %0d/%0d/%h/%0d",
                                            got.status, got.slot_out, got.handle_out,
                                            got.flag_out));
                end else begin
                    exp_res = expected_results.pop_front();
                    if (got.status !== exp_res.status || got.slot_out !== exp_res.slot_out ||
                        got.handle_out !== exp_res.handle_out ||
                        got.flag_out !== exp_res.flag_out)
                        note_mismatch($sformatf(
                            "result %0d exp %0d/%0d/%h/%0d got %0d/%0d/%h/%0d",
                            results_seen, exp_res.status, exp_res.slot_out, exp_res.handle_out,
                            exp_res.flag_out, got.status, got.slot_out, got.handle_out,
                            got.flag_out));
                end
                if (sink_calm > 0) begin
                    sink_calm--;
                end else begin
                    sink_gap = pick_gap();
                    if ($urandom_range(0, 49) == 0) sink_calm = $urandom_range(20, 60);
                end
            end
            // long back-pressure so the block fills and stalls its input
            if (!hold_done && results_seen >= HOLD_AT) begin
                hold_done = 1'b1;
                sink_gap  = HOLD_CYCLES;
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("descriptor_table_allocator_tb: FAIL");
        $finish;
    end

    initial begin
        int added;
        int random_count;
        int mix_plan[9];
        mix_plan = '{MIX_FILL, MIX_CHURN, MIX_CHURN, MIX_DRAIN, MIX_FILL,
                     MIX_CHURN, MIX_DRAIN, MIX_FILL, MIX_CHURN};

        // empty table cases
        add_op(OP_LOOKUP, 0, 0, '0, 1'b0);
        add_op(OP_REMOVE_RANGE, 0, SLOTS - 1, '0, 1'b0);
        add_op(OP_EXEC_CLEAR, 0, 0, '0, 1'b0);
        // inserts at the extremes
        add_op(OP_INSERT_LOWEST, 0, 0, '0, 1'b0);
        add_op(OP_INSERT_LOWEST, 0, 0, '1, 1'b1);
        add_op(OP_INSERT_LOWEST, 10, 0, 32'h5a5a_a5a5, 1'b0);
        add_op(OP_INSERT_AT, SLOTS - 1, 0, 32'ha5a5_5a5a, 1'b1);
        add_op(OP_INSERT_AT, SLOTS, 0, '1, 1'b1);
        add_op(OP_INSERT_AT, 255, 255, '1, 1'b1);
        add_op(OP_INSERT_LOWEST, 255, 0, '1, 1'b0);
        add_op(OP_INSERT_LOWEST, 2, 0, 32'h1234_5678, 1'b1);
        // reads, present and absent
        add_op(OP_LOOKUP, 1, 0, '0, 1'b0);
        add_op(OP_LOOKUP, SLOTS - 1, 0, '0, 1'b0);
        add_op(OP_LOOKUP, 5, 0, '0, 1'b0);
        add_op(OP_LOOKUP, 200, 0, '0, 1'b0);
        add_op(OP_TEST_FLAG, 1, 0, '0, 1'b0);
        add_op(OP_SET_FLAG, 0, 0, '0, 1'b0);
        add_op(OP_TEST_FLAG, 0, 0, '0, 1'b0);
        add_op(OP_SET_FLAG, 7, 0, '0, 1'b0);
        // ranges clamped and reversed
        add_op(OP_REMOVE_RANGE, 255, 0, '0, 1'b0);
        add_op(OP_FLAG_RANGE, 10, 255, '0, 1'b0);
        add_op(OP_REMOVE, 10, 0, '0, 1'b0);
        add_op(OP_REMOVE, 10, 0, '0, 1'b0);
        add_op(OP_EXEC_CLEAR, 0, 0, '0, 1'b0);
        add_op(OP_LOOKUP, 1, 0, '0, 1'b0);
        add_op(OP_FIRST_UNUSED, 3, 4, '1, 1'b1);
        add_op(OP_LAST_UNUSED, 255, 255, '1, 1'b1);
        add_op(OP_REMOVE_RANGE, 0, 255, '0, 1'b0);
        add_op(OP_INSERT_LOWEST, 0, 0, 32'hdead_0001, 1'b0);
        add_idle_wait();

        random_count = 0;
        for (int b = 0; b < 9; b++) begin
            if (b == 5) add_idle_wait();
            while (random_count < (b + 1) * BLOCK_ITEMS) begin
                add_random_op(mix_plan[b], added);
                random_count += added;
            end
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (pending_ops.size() != 0 || next_valid || s_tvalid ||
               expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("descriptor_table_allocator_tb: PASS");
        else
            $display("descriptor_table_allocator_tb: FAIL");
        $finish;
    end

endmodule

>>> files.f
design/dta_pkg.sv
design/dta_ram.sv
design/dta_ctrl.sv
design/dta_datapath.sv
design/descriptor_table_allocator.sv
verif/descriptor_table_allocator_tb.sv
